FILE: hdl/bmhq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types for the binary min-heap queue: command and status codes and
// the sequencer states.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_PEEK  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_TEST,
      S_UP_CMP,
      S_POP_ROOT,
      S_POP_LAST,
      S_DN_TEST,
      S_DN_LEFT,
      S_DN_CHOOSE,
      S_DN_CMP,
      S_FINISH
   } state_type;

endpackage
`default_nettype wire

FILE: hdl/bmhq_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmhq_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/bmhq_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_seq
// Command sequencer: walks the heap one level at a time with a single key
// comparator, moving the hole up (push) or down (pop) through the memory.
// ----------------------------------------------------------------------------
module bmhq_seq #(
   parameter int DEPTH        = 256,
   parameter int KEY_BITS     = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire bmhq_pkg::cmd_type                cmd,
   input  wire logic [KEY_BITS-1:0]              key,
   input  wire logic [PAYLOAD_BITS-1:0]          payload,
   input  wire logic                             out_free,
   output logic                                  idle,
   output logic                                  done,
   output logic      [KEY_BITS-1:0]              res_key,
   output logic      [PAYLOAD_BITS-1:0]          res_payload,
   output bmhq_pkg::status_type                  res_status,
   output logic      [$clog2(DEPTH+1)-1:0]       res_count,
   output logic                                  mem_wr_en,
   output logic      [$clog2(DEPTH)-1:0]         mem_wr_addr,
   output logic      [KEY_BITS+PAYLOAD_BITS-1:0] mem_wr_data,
   output logic                                  mem_rd_en,
   output logic      [$clog2(DEPTH)-1:0]         mem_rd_addr,
   input  wire logic [KEY_BITS+PAYLOAD_BITS-1:0] mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int XW = AW + 2;

   bmhq_pkg::state_type  state_ff, state_in;
   bmhq_pkg::cmd_type    op_ff, op_in;
   bmhq_pkg::status_type res_status_ff, res_status_in;

   logic [AW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [KEY_BITS-1:0]     ent_key_ff, ent_key_in;
   logic [PAYLOAD_BITS-1:0] ent_pay_ff, ent_pay_in;
   logic [KEY_BITS-1:0]     chd_key_ff, chd_key_in;
   logic [PAYLOAD_BITS-1:0] chd_pay_ff, chd_pay_in;
   logic [AW-1:0]           chd_idx_ff, chd_idx_in;
   logic [KEY_BITS-1:0]     res_key_ff, res_key_in;
   logic [PAYLOAD_BITS-1:0] res_pay_ff, res_pay_in;

   logic [KEY_BITS-1:0]     rd_key;
   logic [PAYLOAD_BITS-1:0] rd_pay;
   logic [KEY_BITS-1:0]     cmp_a;
   logic [KEY_BITS-1:0]     cmp_b;
   logic                    cmp_lt;
   logic [AW-1:0]           pos_m1;
   logic [AW-1:0]           parent;
   logic [XW-1:0]           left_x;
   logic [XW-1:0]           right_x;
   logic [XW-1:0]           count_x;
   logic [CW-1:0]           count_m1;
   logic                    full;
   logic                    empty;

   assign rd_key   = mem_rd_data[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS];
   assign rd_pay   = mem_rd_data[PAYLOAD_BITS-1:0];
   assign pos_m1   = pos_ff - AW'(1);
   assign parent   = pos_m1 >> 1;
   assign left_x   = {1'b0, pos_ff, 1'b1};
   assign right_x  = left_x + XW'(1);
   assign count_x  = XW'(count_ff);
   assign count_m1 = count_ff - CW'(1);
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == CW'(0));

   // shared key comparator and its operand select
   always_comb begin
      cmp_a = '0;
      cmp_b = '0;
      case (state_ff)
         bmhq_pkg::S_UP_CMP: begin
            cmp_a = ent_key_ff;
            cmp_b = rd_key;
         end
         bmhq_pkg::S_DN_CHOOSE: begin
            // left wins a tie
            cmp_a = rd_key;
            cmp_b = chd_key_ff;
         end
         bmhq_pkg::S_DN_CMP: begin
            cmp_a = chd_key_ff;
            cmp_b = ent_key_ff;
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   assign cmp_lt = (cmp_a < cmp_b);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (start) begin
               case (cmd)
                  bmhq_pkg::CMD_PUSH:
                     state_in = full ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_TEST;
                  bmhq_pkg::CMD_POP, bmhq_pkg::CMD_PEEK:
                     state_in = empty ? bmhq_pkg::S_FINISH : bmhq_pkg::S_POP_ROOT;
                  default:
                     state_in = bmhq_pkg::S_FINISH;
               endcase
            end
         end
         bmhq_pkg::S_UP_TEST: begin
            state_in = (pos_ff == AW'(0)) ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_CMP;
         end
         bmhq_pkg::S_UP_CMP: begin
            state_in = cmp_lt ? bmhq_pkg::S_UP_TEST : bmhq_pkg::S_FINISH;
         end
         bmhq_pkg::S_POP_ROOT: begin
            if (op_ff == bmhq_pkg::CMD_PEEK || count_ff == CW'(1)) begin
               state_in = bmhq_pkg::S_FINISH;
            end else begin
               state_in = bmhq_pkg::S_POP_LAST;
            end
         end
         bmhq_pkg::S_POP_LAST: begin
            state_in = bmhq_pkg::S_DN_TEST;
         end
         bmhq_pkg::S_DN_TEST: begin
            state_in = (left_x >= count_x) ? bmhq_pkg::S_FINISH : bmhq_pkg::S_DN_LEFT;
         end
         bmhq_pkg::S_DN_LEFT: begin
            state_in = (right_x < count_x) ? bmhq_pkg::S_DN_CHOOSE : bmhq_pkg::S_DN_CMP;
         end
         bmhq_pkg::S_DN_CHOOSE: begin
            state_in = bmhq_pkg::S_DN_CMP;
         end
         bmhq_pkg::S_DN_CMP: begin
            state_in = cmp_lt ? bmhq_pkg::S_DN_TEST : bmhq_pkg::S_FINISH;
         end
         bmhq_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = bmhq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bmhq_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      op_in         = op_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      ent_key_in    = ent_key_ff;
      ent_pay_in    = ent_pay_ff;
      chd_key_in    = chd_key_ff;
      chd_pay_in    = chd_pay_ff;
      chd_idx_in    = chd_idx_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      res_status_in = res_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pos_ff;
      mem_wr_data   = {ent_key_ff, ent_pay_ff};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      done          = 1'b0;
      idle          = 1'b0;

      case (state_ff)
         bmhq_pkg::S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               op_in         = cmd;
               res_key_in    = '0;
               res_pay_in    = '0;
               res_status_in = bmhq_pkg::STAT_OK;
               case (cmd)
                  bmhq_pkg::CMD_PUSH: begin
                     if (full) begin
                        res_status_in = bmhq_pkg::STAT_FULL;
                     end else begin
                        ent_key_in = key;
                        ent_pay_in = payload;
                        pos_in     = count_ff[AW-1:0];
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  bmhq_pkg::CMD_POP, bmhq_pkg::CMD_PEEK: begin
                     if (empty) begin
                        res_status_in = bmhq_pkg::STAT_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         bmhq_pkg::S_UP_TEST: begin
            if (pos_ff == AW'(0)) begin
               mem_wr_en = 1'b1;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = parent;
            end
         end
         bmhq_pkg::S_UP_CMP: begin
            mem_wr_en = 1'b1;
            if (cmp_lt) begin
               mem_wr_data = mem_rd_data;
               pos_in      = parent;
            end
         end
         bmhq_pkg::S_POP_ROOT: begin
            res_key_in = rd_key;
            res_pay_in = rd_pay;
            if (op_ff == bmhq_pkg::CMD_POP) begin
               count_in = count_m1;
               if (count_ff != CW'(1)) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = count_m1[AW-1:0];
               end
            end
         end
         bmhq_pkg::S_POP_LAST: begin
            ent_key_in = rd_key;
            ent_pay_in = rd_pay;
            pos_in     = '0;
         end
         bmhq_pkg::S_DN_TEST: begin
            if (left_x >= count_x) begin
               mem_wr_en = 1'b1;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = left_x[AW-1:0];
            end
         end
         bmhq_pkg::S_DN_LEFT: begin
            chd_key_in = rd_key;
            chd_pay_in = rd_pay;
            chd_idx_in = left_x[AW-1:0];
            if (right_x < count_x) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = right_x[AW-1:0];
            end
         end
         bmhq_pkg::S_DN_CHOOSE: begin
            if (cmp_lt) begin
               chd_key_in = rd_key;
               chd_pay_in = rd_pay;
               chd_idx_in = right_x[AW-1:0];
            end
         end
         bmhq_pkg::S_DN_CMP: begin
            mem_wr_en = 1'b1;
            if (cmp_lt) begin
               mem_wr_data = {chd_key_ff, chd_pay_ff};
               pos_in      = chd_idx_ff;
            end
         end
         bmhq_pkg::S_FINISH: begin
            done = out_free;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      ent_key_ff    <= ent_key_in;
      ent_pay_ff    <= ent_pay_in;
      chd_key_ff    <= chd_key_in;
      chd_pay_ff    <= chd_pay_in;
      chd_idx_ff    <= chd_idx_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      res_status_ff <= res_status_in;
   end

   assign res_key     = res_key_ff;
   assign res_payload = res_pay_ff;
   assign res_status  = res_status_ff;
   assign res_count   = count_ff;

endmodule
`default_nettype wire

FILE: hdl/binary_min_heap_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Priority queue on a binary min-heap of key/payload entries.
// ----------------------------------------------------------------------------
// Takes one command at a time (push, pop, peek, clear) and returns one result
// transfer per command; req_stall is high from acceptance until the result is
// handed to the output register, which holds it while the next command runs.
// The heap lives in a single-port-read, single-port-write memory walked by one
// key comparator, one level per step. A push moves the new entry up from the
// end of the heap; a pop moves the last entry down from the root. A finished
// result waits for the output register to free up. A push to a full heap is
// dropped with status full; pop or peek on an empty heap returns status empty.
// Smaller keys leave first; entries with equal keys may leave in any order.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit #(
   parameter int DEPTH        = 256,
   parameter int KEY_BITS     = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [bmhq_pkg::CMD_W-1:0]          req_command,
   input  wire logic [KEY_BITS-1:0]                 req_key,
   input  wire logic [PAYLOAD_BITS-1:0]             req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [KEY_BITS-1:0]                 rsp_out_key,
   output logic      [PAYLOAD_BITS-1:0]             rsp_out_payload,
   output logic      [bmhq_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [$clog2(DEPTH+1)-1:0]          rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int EW = KEY_BITS + PAYLOAD_BITS;

   logic                    idle;
   logic                    start;
   logic                    done;
   logic                    out_free;
   logic [KEY_BITS-1:0]     res_key;
   logic [PAYLOAD_BITS-1:0] res_payload;
   bmhq_pkg::status_type    res_status;
   logic [CW-1:0]           res_count;
   logic                    mem_wr_en;
   logic [AW-1:0]           mem_wr_addr;
   logic [EW-1:0]           mem_wr_data;
   logic                    mem_rd_en;
   logic [AW-1:0]           mem_rd_addr;
   logic [EW-1:0]           mem_rd_data;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]           rsp_key_ff;
   logic [PAYLOAD_BITS-1:0]       rsp_pay_ff;
   logic [bmhq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [CW-1:0]                 rsp_count_ff;

   assign req_stall = ~idle;
   assign start     = req_valid & idle;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   bmhq_seq #(
      .DEPTH        (DEPTH),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (bmhq_pkg::cmd_type'(req_command)),
      .key         (req_key),
      .payload     (req_payload),
      .out_free    (out_free),
      .idle        (idle),
      .done        (done),
      .res_key     (res_key),
      .res_payload (res_payload),
      .res_status  (res_status),
      .res_count   (res_count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bmhq_mem #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_key_ff    <= res_key;
         rsp_pay_ff    <= res_payload;
         rsp_status_ff <= res_status;
         rsp_count_ff  <= res_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;

endmodule
`default_nettype wire

FILE: hdl/bmhq_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_chk
// Port-level checks for the binary min-heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_chk #(
   parameter int DEPTH        = 256,
   parameter int KEY_BITS     = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [KEY_BITS-1:0]           rsp_out_key,
   input wire logic [PAYLOAD_BITS-1:0]       rsp_out_payload,
   input wire logic [bmhq_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [$clog2(DEPTH+1)-1:0]    rsp_count
);

   localparam int CW = $clog2(DEPTH+1);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one command in flight: a transfer in stalls the input next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a command is in progress");

   // empty status only with an empty heap and no data
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmhq_pkg::STAT_EMPTY) |->
         (rsp_count == CW'(0) && rsp_out_key == '0 && rsp_out_payload == '0))
      else $error("empty status with entries or data");

   // full status only with a full heap
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmhq_pkg::STAT_FULL) |->
         (rsp_count == CW'(DEPTH) && rsp_out_key == '0))
      else $error("full status on a heap that is not full");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_count) && $stable(rsp_out_key) &&
          $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind binary_min_heap_queue_unit bmhq_chk #(
   .DEPTH        (DEPTH),
   .KEY_BITS     (KEY_BITS),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_bmhq_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_key     (rsp_out_key),
   .rsp_out_payload (rsp_out_payload),
   .rsp_status      (rsp_status),
   .rsp_count       (rsp_count)
);
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_min_heap_queue_unit. A directed command
// table runs first, covering the empty, equal-key and clear cases. A random
// phase follows: it fills the heap to the top, overflows it, drains it past
// empty, then runs a random command mix. An in-bench heap model predicts each
// result the table does not give. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HEAP_DEPTH     = 256;
   localparam int DIR_ROWS       = 21;
   localparam int MIX_ITEMS      = 560;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [15:0]          key;
      logic [15:0]          payload;
      bmhq_pkg::status_type status;
      logic [8:0]           count;
   } heap_result_type;

   typedef struct packed {
      bmhq_pkg::cmd_type cmd;
      logic [15:0]       key;
      logic [15:0]       payload;
      bit                typed;
      heap_result_type   res;
   } cmd_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bmhq_pkg::cmd_type req_command = bmhq_pkg::CMD_CLEAR;
   logic [15:0]       req_key = '0;
   logic [15:0]       req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [15:0]       rsp_out_key;
   logic [15:0]       rsp_out_payload;
   logic [1:0]        rsp_status;
   logic [8:0]        rsp_count;

   // model heap
   logic [15:0] hk [HEAP_DEPTH];
   logic [15:0] hp [HEAP_DEPTH];
   int unsigned fill = 0;

   heap_result_type pending_results [$];
   int              mismatch_count = 0;
   int              burst_left = 0;
   int              quiet_cycles = 0;
   int              stall_left = 0;
   int              stall_mode = 0;

   cmd_row_type directed [0:DIR_ROWS-1] = '{
      '{bmhq_pkg::CMD_POP,   16'hFFFF, 16'hFFFF, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_EMPTY, 9'd0}},
      '{bmhq_pkg::CMD_PEEK,  16'h0000, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_EMPTY, 9'd0}},
      '{bmhq_pkg::CMD_CLEAR, 16'hFFFF, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd0}},
      '{bmhq_pkg::CMD_PUSH,  16'hFFFF, 16'hFFFF, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd1}},
      '{bmhq_pkg::CMD_PUSH,  16'h0000, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd2}},
      '{bmhq_pkg::CMD_PEEK,  16'h0000, 16'hFFFF, 1'b0,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd2}},
      '{bmhq_pkg::CMD_PUSH,  16'h0000, 16'h1234, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd3}},
      '{bmhq_pkg::CMD_PEEK,  16'h0000, 16'h0000, 1'b0,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd3}},
      '{bmhq_pkg::CMD_PUSH,  16'h8000, 16'h5555, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd4}},
      '{bmhq_pkg::CMD_PUSH,  16'h8000, 16'hAAAA, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd5}},
      '{bmhq_pkg::CMD_POP,   16'h0000, 16'h0000, 1'b0,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd4}},
      '{bmhq_pkg::CMD_POP,   16'h0000, 16'h0000, 1'b0,
        '{16'h0000, 16'h1234, bmhq_pkg::STAT_OK,    9'd3}},
      '{bmhq_pkg::CMD_POP,   16'h0000, 16'h0000, 1'b0,
        '{16'h8000, 16'h5555, bmhq_pkg::STAT_OK,    9'd2}},
      '{bmhq_pkg::CMD_POP,   16'h0000, 16'h0000, 1'b0,
        '{16'h8000, 16'hAAAA, bmhq_pkg::STAT_OK,    9'd1}},
      '{bmhq_pkg::CMD_POP,   16'h0000, 16'h0000, 1'b1,
        '{16'hFFFF, 16'hFFFF, bmhq_pkg::STAT_OK,    9'd0}},
      '{bmhq_pkg::CMD_POP,   16'h0000, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_EMPTY, 9'd0}},
      '{bmhq_pkg::CMD_PUSH,  16'h0007, 16'h0F0F, 1'b0,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd0}},
      '{bmhq_pkg::CMD_PUSH,  16'h0003, 16'hF0F0, 1'b0,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd0}},
      '{bmhq_pkg::CMD_PEEK,  16'h0000, 16'h0000, 1'b0,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd0}},
      '{bmhq_pkg::CMD_CLEAR, 16'h0000, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_OK,    9'd0}},
      '{bmhq_pkg::CMD_PEEK,  16'h0000, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, bmhq_pkg::STAT_EMPTY, 9'd0}}
   };

   binary_min_heap_queue_unit #(
      .DEPTH        (HEAP_DEPTH),
      .KEY_BITS     (16),
      .PAYLOAD_BITS (16)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [15:0] tk;
      logic [15:0] tp;
      tk = hk[a];
      tp = hp[a];
      hk[a] = hk[b];
      hp[a] = hp[b];
      hk[b] = tk;
      hp[b] = tp;
   endfunction

   function automatic heap_result_type heap_apply(bmhq_pkg::cmd_type c,
                                                  logic [15:0] k,
                                                  logic [15:0] p);
      heap_result_type r;
      int unsigned     pos;
      int unsigned     up;
      int unsigned     kid;
      bit              moving;
      r = '0;
      r.status = bmhq_pkg::STAT_OK;
      case (c)
         bmhq_pkg::CMD_PUSH: begin
            if (fill >= HEAP_DEPTH) begin
               r.status = bmhq_pkg::STAT_FULL;
            end else begin
               pos = fill;
               hk[pos] = k;
               hp[pos] = p;
               fill++;
               moving = 1'b1;
               while (moving && pos > 0) begin
                  up = (pos - 1) / 2;
                  if (hk[pos] < hk[up]) begin
                     swap_slots(pos, up);
                     pos = up;
                  end else begin
                     moving = 1'b0;
                  end
               end
            end
         end
         bmhq_pkg::CMD_POP, bmhq_pkg::CMD_PEEK: begin
            if (fill == 0) begin
               r.status = bmhq_pkg::STAT_EMPTY;
            end else begin
               r.key = hk[0];
               r.payload = hp[0];
               if (c == bmhq_pkg::CMD_POP) begin
                  fill--;
                  hk[0] = hk[fill];
                  hp[0] = hp[fill];
                  pos = 0;
                  moving = 1'b1;
                  while (moving) begin
                     kid = 2 * pos + 1;
                     if (kid >= fill) begin
                        moving = 1'b0;
                     end else begin
                        // ties go to the left child
                        if (kid + 1 < fill && hk[kid+1] < hk[kid])
                           kid++;
                        if (hk[pos] > hk[kid]) begin
                           swap_slots(pos, kid);
                           pos = kid;
                        end else begin
                           moving = 1'b0;
                        end
                     end
                  end
               end
            end
         end
         default: fill = 0;
      endcase
      r.count = 9'(fill);
      return r;
   endfunction

   // skew toward small keys so equal keys are common
   function automatic logic [15:0] pick_key();
      int sel;
      sel = $urandom_range(0, 3);
      if (sel < 2)
         return 16'($urandom_range(0, 15));
      else if (sel == 2)
         return 16'($urandom_range(0, 65535));
      else
         return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
   endfunction

   task automatic issue(input bmhq_pkg::cmd_type c, input logic [15:0] k,
                        input logic [15:0] p, input bit typed,
                        input heap_result_type given);
      heap_result_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_command = c;
      req_key = k;
      req_payload = p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = heap_apply(c, k, p);
      pending_results.push_back(typed ? given : r);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 1) == 1);
         2: rsp_stall = (stall_left % 3 == 0);
         default: rsp_stall = ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected transfer key=%h payload=%h status=%0d count=%0d",
                        rsp_out_key, rsp_out_payload, rsp_status, rsp_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_key !== want.key || rsp_out_payload !== want.payload ||
                rsp_status !== want.status || rsp_count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"ERROR: exp key=%h payload=%h status=%0d count=%0d, ",
                            "got key=%h payload=%h status=%0d count=%0d"},
                           want.key, want.payload, want.status, want.count,
                           rsp_out_key, rsp_out_payload, rsp_status, rsp_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int i;
      int sel;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         issue(directed[i].cmd, directed[i].key, directed[i].payload,
               directed[i].typed, directed[i].res);
      wait_drained();

      // fill to the top, overflow, then drain past empty
      while (fill < HEAP_DEPTH)
         issue(bmhq_pkg::CMD_PUSH, pick_key(), 16'($urandom), 1'b0, '0);
      repeat (4) issue(bmhq_pkg::CMD_PUSH, pick_key(), 16'($urandom), 1'b0, '0);
      issue(bmhq_pkg::CMD_PEEK, 16'($urandom), 16'($urandom), 1'b0, '0);
      repeat (HEAP_DEPTH + 1)
         issue(bmhq_pkg::CMD_POP, 16'($urandom), 16'($urandom), 1'b0, '0);
      wait_drained();

      for (i = 0; i < MIX_ITEMS; i++) begin
         if ($urandom_range(0, 99) == 0)
            wait_drained();
         sel = $urandom_range(0, 99);
         if (sel < 50)
            issue(bmhq_pkg::CMD_PUSH, pick_key(), 16'($urandom), 1'b0, '0);
         else if (sel < 88)
            issue(bmhq_pkg::CMD_POP, 16'($urandom), 16'($urandom), 1'b0, '0);
         else if (sel < 98)
            issue(bmhq_pkg::CMD_PEEK, 16'($urandom), 16'($urandom), 1'b0, '0);
         else
            issue(bmhq_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 1'b0, '0);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
